FILE: hw/rtl/pqdt_pkg.sv
package pqdt_pkg;

    localparam int FUNC_W = 2;
    localparam int INDEX_W = 11;
    localparam int VALUE_W = 16;
    localparam int SUB_W = 5;
    localparam int CENT_W = 6;
    localparam int DIST_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_CB = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_MEAN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [SUB_W-1:0]  subspace;
        logic [CENT_W-1:0] centroid;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_acc;
        logic prep;
        logic issue;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic query_ok;
        logic last_elem;
        logic issue_last;
        logic pipe_busy;
        logic emit_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hw/rtl/pqdt_ctrl.sv
module pqdt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pqdt_pkg::t_dp_stat i_stat,
    output logic               o_in_stall,
    output pqdt_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ACC,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_acc = i_in_valid;
                if (i_in_valid && i_stat.query_ok) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.issue = 1'b1;
                if (i_stat.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = i_stat.last_elem ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // The square-and-add pipeline must be empty whenever a new item can enter.
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.pipe_busy)
        else $error("pipeline busy while idle");

    // Emission reads the sums, so no accumulation may still be in flight.
    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_stat.pipe_busy)
        else $error("emitting with accumulation in flight");

    a_last_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && i_stat.issue_last) |=> (r_state == S_DRAIN))
        else $error("issue did not stop after the last centroid");

endmodule

FILE: hw/rtl/pqdt_dpath.sv
module pqdt_dpath #(
    parameter int SUBSPACES = 16,
    parameter int SUB_DIM = 8,
    parameter int CENTROIDS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pqdt_pkg::t_in_item  i_in_item,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_data,
    input  pqdt_pkg::t_dp_cmd   i_cmd,
    output pqdt_pkg::t_dp_stat  o_stat,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output pqdt_pkg::t_out_item o_out_item
);

    localparam int SW = pqdt_pkg::SUB_W;
    localparam int IW = pqdt_pkg::INDEX_W;
    localparam int VEC_DIM = SUBSPACES * SUB_DIM;
    localparam int VI_W = $clog2(VEC_DIM);
    localparam int TAB_N = 1 << VI_W;
    localparam int D_W = $clog2(SUB_DIM);
    localparam int CI_W = $clog2(CENTROIDS);
    localparam int WID_N = SUB_DIM;
    localparam int WID_L = SUB_DIM / 2;
    localparam logic [IW-1:0] LIM_N = IW'(VEC_DIM);
    localparam logic [IW-1:0] LIM_L = IW'(2 * SUBSPACES * WID_L);
    localparam logic [IW-1:0] CW_N = IW'(CENTROIDS * WID_N);
    localparam logic [IW-1:0] CW_L = IW'(CENTROIDS * WID_L);
    localparam logic [IW-1:0] STEP_N = IW'(WID_N);
    localparam logic [IW-1:0] STEP_L = IW'(WID_L);
    localparam logic [D_W-1:0] DLAST_N = D_W'(WID_N - 1);
    localparam logic [D_W-1:0] DLAST_L = D_W'(WID_L - 1);
    localparam logic [CI_W-1:0] CLAST = CI_W'(CENTROIDS - 1);
    localparam int CB_DEPTH = 1 << IW;

    typedef struct packed {
        logic [SW-1:0]  s;
        logic [D_W-1:0] d;
    } t_split;

    typedef t_split [TAB_N-1:0] t_split_tab;

    // Maps a vector index to its subspace and position, counting rather than dividing.
    function automatic t_split_tab f_split(input int wid);
        t_split_tab tab;
        int s;
        int d;
        tab = '0;
        s = 0;
        d = 0;
        for (int i = 0; i < TAB_N; i++) begin
            tab[i].s = SW'(s);
            tab[i].d = D_W'(d);
            if (d == wid - 1) begin
                d = 0;
                s = s + 1;
            end else begin
                d = d + 1;
            end
        end
        return tab;
    endfunction

    localparam t_split_tab SPLIT_N = f_split(WID_N);
    localparam t_split_tab SPLIT_L = f_split(WID_L);

    logic signed [pqdt_pkg::VALUE_W-1:0] r_cb_mem [CB_DEPTH];
    logic signed [pqdt_pkg::VALUE_W-1:0] r_mean_mem [VEC_DIM];
    logic signed [pqdt_pkg::VALUE_W-1:0] r_cb_q;
    logic signed [pqdt_pkg::VALUE_W-1:0] r_mean_q;
    logic [31:0] r_sums [CENTROIDS];

    logic r_long;
    logic r_lq;
    logic signed [pqdt_pkg::VALUE_W-1:0] r_val;
    logic [SW-1:0] r_s;
    logic [D_W-1:0] r_d;
    logic signed [16:0] r_q;
    logic [IW-1:0] r_addr;
    logic [CI_W-1:0] r_ic;
    logic [CI_W-1:0] r_ec;
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic [CI_W-1:0] r_c1;
    logic [CI_W-1:0] r_c2;
    logic [CI_W-1:0] r_c3;
    logic signed [17:0] r_diff;
    logic [31:0] r_sq;
    logic r_out_valid;
    pqdt_pkg::t_out_item r_out;

    logic [VI_W-1:0] idx_lo;
    t_split split;
    logic cb_we;
    logic mean_we;
    logic [IW-1:0] base;
    logic [CI_W-1:0] sum_idx;
    logic [31:0] sum_rd;
    logic signed [35:0] sq_full;
    logic out_free;

    assign idx_lo = i_in_item.index[VI_W-1:0];
    assign split = r_long ? SPLIT_L[idx_lo] : SPLIT_N[idx_lo];
    assign cb_we = i_cmd.in_acc && (i_in_item.func == pqdt_pkg::FUNC_LOAD_CB);
    assign mean_we = i_cmd.in_acc && (i_in_item.func == pqdt_pkg::FUNC_LOAD_MEAN)
                     && (i_in_item.index < LIM_N);
    assign base = IW'(r_s) * (r_lq ? CW_L : CW_N) + IW'(r_d);
    assign sum_idx = i_cmd.emit ? r_ec : r_c3;
    assign sum_rd = r_sums[sum_idx];
    assign sq_full = r_diff * r_diff;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.query_ok = (i_in_item.func == pqdt_pkg::FUNC_QUERY)
                          && (i_in_item.index < (r_long ? LIM_L : LIM_N));
        o_stat.last_elem = (r_d == (r_lq ? DLAST_L : DLAST_N));
        o_stat.issue_last = (r_ic == CLAST);
        o_stat.pipe_busy = r_v1 || r_v2 || r_v3;
        o_stat.emit_last = (r_ec == CLAST);
        o_stat.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (cb_we) begin
            r_cb_mem[i_in_item.index] <= i_in_item.value;
        end
        r_cb_q <= r_cb_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mean_we) begin
            r_mean_mem[idx_lo] <= i_in_item.value;
        end
        r_mean_q <= r_mean_mem[idx_lo];
    end

    // Item capture and the square-and-add pipeline payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_acc) begin
            r_val <= i_in_item.value;
            r_s <= split.s;
            r_d <= split.d;
            r_lq <= r_long;
        end
        if (i_cmd.prep) begin
            r_q <= 17'(r_val) - 17'(r_mean_q);
            r_addr <= base;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + (r_lq ? STEP_L : STEP_N);
        end
        r_c1 <= r_ic;
        r_c2 <= r_c1;
        r_c3 <= r_c2;
        r_diff <= 18'(r_cb_q) - 18'(r_q);
        r_sq <= sq_full[31:0];
        if (i_cmd.emit) begin
            r_out.subspace <= r_s;
            r_out.centroid <= pqdt_pkg::CENT_W'(r_ec);
            r_out.distance <= sum_rd;
            r_out.last <= o_stat.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long <= 1'b0;
            r_ic <= '0;
            r_ec <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CENTROIDS; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_long <= i_cfg_data;
            end
            if (i_cmd.prep) begin
                r_ic <= '0;
                r_ec <= '0;
            end else begin
                if (i_cmd.issue) begin
                    r_ic <= r_ic + 1'b1;
                end
                if (i_cmd.emit) begin
                    r_ec <= r_ec + 1'b1;
                end
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            // The first element of a subvector restarts every sum.
            if (r_v3) begin
                r_sums[r_c3] <= (r_d == '0) ? r_sq : sum_rd + r_sq;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result loaded over an item still waiting");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && (r_out.centroid == pqdt_pkg::CENT_W'($past(r_ec)))))
        else $error("emitted result not presented");

endmodule

FILE: hw/rtl/pq_distance_table_builder_unit.sv
// Load items (codebook word, mean element) are taken one per cycle, back to back, while idle.
// For a query element, one shared subtract-square-add unit walks the centroids
// one per cycle behind a codebook memory read port.
// The last element of a subvector then emits CENTROIDS results,
// one result per cycle while the output does not stall.
// Reset is synchronous, active low: it clears mode, sums and control, not the stores.
module pq_distance_table_builder_unit #(
    parameter int SUBSPACES = 16,
    parameter int SUB_DIM = 8,
    parameter int CENTROIDS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pqdt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pqdt_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    pqdt_pkg::t_dp_cmd  cmd;
    pqdt_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    pqdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pqdt_dpath #(
        .SUBSPACES (SUBSPACES),
        .SUB_DIM   (SUB_DIM),
        .CENTROIDS (CENTROIDS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: bench/tb.sv
module tb;

    localparam int SUBSPACES = 16;
    localparam int SUB_DIM = 8;
    localparam int CENTROIDS = 16;
    localparam int VEC_DIM = SUBSPACES * SUB_DIM;
    localparam int CB_DEPTH = 2048;
    localparam int CB_SPAN = CENTROIDS * SUB_DIM;
    localparam logic [pqdt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    // A query with no result may still occupy the datapath after its item is accepted.
    localparam int SETTLE_CYCLES = 2 * (CENTROIDS + 5) + 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 25;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    pqdt_pkg::t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    pqdt_pkg::t_out_item o_out_item;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data = 1'b0;

    // Mirror of the block state used to predict the distance table.
    logic [pqdt_pkg::VALUE_W-1:0] codebook_copy [CB_DEPTH];
    logic [pqdt_pkg::VALUE_W-1:0] mean_copy [VEC_DIM];
    logic [pqdt_pkg::DIST_W-1:0] centroid_acc [CENTROIDS];
    logic long_sel = 1'b0;

    pqdt_pkg::t_out_item table_rows [$];
    pqdt_pkg::t_in_item pending_items [$];
    int items_queued = 0;
    int items_accepted = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int idle_odds = 0;
    int in_gap = 0;
    int out_gap = 0;
    logic in_taken = 1'b0;

    pq_distance_table_builder_unit #(
        .SUBSPACES(SUBSPACES),
        .SUB_DIM(SUB_DIM),
        .CENTROIDS(CENTROIDS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [pqdt_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            default: return pqdt_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    // Queries stay in the first and last codebook regions, which are the ones filled.
    function automatic int pick_sub();
        int k;
        k = $urandom_range(0, 3);
        if (!long_sel)
            return (k < 2) ? 0 : SUBSPACES - 1;
        return (k < 2) ? k : 2 * SUBSPACES - 4 + k;
    endfunction

    task automatic queue_item(input logic [pqdt_pkg::FUNC_W-1:0] func, input int index,
                              input logic [pqdt_pkg::VALUE_W-1:0] value);
        pqdt_pkg::t_in_item it;
        it.func = func;
        it.index = index[pqdt_pkg::INDEX_W-1:0];
        it.value = value;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Applies one accepted item to the mirror and queues the distances it releases.
    task automatic update_table(input pqdt_pkg::t_in_item it);
        int width;
        int nsub;
        int sub;
        int pos;
        int addr;
        longint centred;
        longint diff;
        logic [63:0] square;
        pqdt_pkg::t_out_item row;
        width = long_sel ? SUB_DIM / 2 : SUB_DIM;
        nsub = long_sel ? 2 * SUBSPACES : SUBSPACES;
        case (it.func)
            pqdt_pkg::FUNC_LOAD_CB: codebook_copy[it.index] = it.value;
            pqdt_pkg::FUNC_LOAD_MEAN: begin
                if (it.index < VEC_DIM)
                    mean_copy[it.index] = it.value;
            end
            pqdt_pkg::FUNC_QUERY: begin
                if (it.index < nsub * width && it.index < VEC_DIM) begin
                    sub = it.index / width;
                    pos = it.index % width;
                    centred = longint'($signed(it.value))
                              - longint'($signed(mean_copy[it.index]));
                    for (int c = 0; c < CENTROIDS; c++) begin
                        addr = ((sub * CENTROIDS + c) * width + pos) % CB_DEPTH;
                        diff = longint'($signed(codebook_copy[addr])) - centred;
                        if (diff < 0)
                            diff = -diff;
                        square = diff * diff;
                        if (pos == 0)
                            centroid_acc[c] = square[pqdt_pkg::DIST_W-1:0];
                        else
                            centroid_acc[c] = centroid_acc[c] + square[pqdt_pkg::DIST_W-1:0];
                    end
                    if (pos == width - 1) begin
                        for (int c = 0; c < CENTROIDS; c++) begin
                            row.subspace = sub[pqdt_pkg::SUB_W-1:0];
                            row.centroid = c[pqdt_pkg::CENT_W-1:0];
                            row.distance = centroid_acc[c];
                            row.last = (c == CENTROIDS - 1);
                            table_rows.push_back(row);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        pqdt_pkg::t_out_item want;
        if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                update_table(i_in_item);
                items_accepted++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (table_rows.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected result: sub %0d cent %0d dist %h last %b",
                                 o_out_item.subspace, o_out_item.centroid,
                                 o_out_item.distance, o_out_item.last);
                    mismatches++;
                end else begin
                    want = table_rows.pop_front();
                    if (o_out_item.subspace !== want.subspace
                            || o_out_item.centroid !== want.centroid
                            || o_out_item.distance !== want.distance
                            || o_out_item.last !== want.last) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("mismatch: expected sub %0d cent %0d dist %h last %b",
                                     want.subspace, want.centroid, want.distance,
                                     want.last,
                                     ", got sub %0d cent %0d dist %h last %b",
                                     o_out_item.subspace, o_out_item.centroid,
                                     o_out_item.distance, o_out_item.last);
                        mismatches++;
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Item driver and output stall, both with random idle bursts.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                    in_gap = $urandom_range(1, 6) - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    i_in_item <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                out_gap = $urandom_range(1, 6) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (items_accepted != items_queued || table_rows.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        long_sel = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly whole subvectors in order, with reloads mixed in; the rest is
    // partial or shuffled subvectors, loose loads and ignored items.
    task automatic build_phase(input int target);
        int width;
        int nsub;
        int done;
        int sub;
        int span;
        int pick;
        width = long_sel ? SUB_DIM / 2 : SUB_DIM;
        nsub = long_sel ? 2 * SUBSPACES : SUBSPACES;
        done = 0;
        while (done < target) begin
            pick = $urandom_range(0, 99);
            sub = pick_sub();
            if (pick < 70) begin
                for (int k = 0; k < width; k++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        queue_item(pqdt_pkg::FUNC_LOAD_CB, $urandom_range(0, CB_DEPTH - 1),
                                   pick_value());
                        done++;
                    end else if ($urandom_range(0, 7) == 0) begin
                        queue_item(pqdt_pkg::FUNC_LOAD_MEAN, sub * width + k, pick_value());
                        done++;
                    end
                    queue_item(pqdt_pkg::FUNC_QUERY, sub * width + k, pick_value());
                    done++;
                end
            end else if (pick < 82) begin
                span = $urandom_range(1, width);
                for (int k = 0; k < span; k++)
                    queue_item(pqdt_pkg::FUNC_QUERY,
                               sub * width + $urandom_range(0, width - 1), pick_value());
                done += span;
            end else if (pick < 92) begin
                queue_item(pqdt_pkg::FUNC_LOAD_MEAN, $urandom_range(0, VEC_DIM - 1),
                           pick_value());
                queue_item(pqdt_pkg::FUNC_LOAD_CB, $urandom_range(0, CB_DEPTH - 1),
                           pick_value());
                done += 2;
            end else begin
                case ($urandom_range(0, 2))
                    0: queue_item(FUNC_UNUSED, $urandom_range(0, CB_DEPTH - 1), pick_value());
                    1: queue_item(pqdt_pkg::FUNC_LOAD_MEAN,
                                  $urandom_range(VEC_DIM, CB_DEPTH - 1), pick_value());
                    default: queue_item(pqdt_pkg::FUNC_QUERY,
                                        $urandom_range(VEC_DIM, CB_DEPTH - 1), pick_value());
                endcase
                done++;
            end
        end
    endtask

    initial begin
        for (int c = 0; c < CENTROIDS; c++)
            centroid_acc[c] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the codebook and mean entries of the first and last subspaces,
        // the only ones that queries touch, so that no query reads an unwritten entry.
        idle_odds = 5;
        for (int a = 0; a < CB_SPAN; a++) begin
            queue_item(pqdt_pkg::FUNC_LOAD_CB, a, pick_value());
            queue_item(pqdt_pkg::FUNC_LOAD_CB, (SUBSPACES - 1) * CB_SPAN + a, pick_value());
        end
        for (int a = 0; a < SUB_DIM; a++) begin
            queue_item(pqdt_pkg::FUNC_LOAD_MEAN, a, pick_value());
            queue_item(pqdt_pkg::FUNC_LOAD_MEAN, VEC_DIM - SUB_DIM + a, pick_value());
        end

        // Extreme values drive the squared distance past 2^32.
        queue_item(pqdt_pkg::FUNC_LOAD_CB, 0, 16'h8000);
        queue_item(pqdt_pkg::FUNC_LOAD_CB, 8, 16'h7FFF);
        queue_item(pqdt_pkg::FUNC_LOAD_CB, CB_DEPTH - 1, 16'h7FFF);
        queue_item(pqdt_pkg::FUNC_LOAD_MEAN, 0, 16'h8000);
        queue_item(pqdt_pkg::FUNC_LOAD_MEAN, VEC_DIM - 1, 16'h7FFF);
        queue_item(pqdt_pkg::FUNC_LOAD_MEAN, VEC_DIM, 16'h0000);
        queue_item(pqdt_pkg::FUNC_LOAD_MEAN, CB_DEPTH - 1, 16'h5555);
        queue_item(FUNC_UNUSED, CB_DEPTH - 1, 16'hFFFF);
        queue_item(pqdt_pkg::FUNC_QUERY, CB_DEPTH - 1, 16'h7FFF);
        queue_item(pqdt_pkg::FUNC_QUERY, VEC_DIM, 16'h8000);
        for (int k = 0; k < SUB_DIM; k++)
            queue_item(pqdt_pkg::FUNC_QUERY, k, 16'h7FFF);
        for (int k = VEC_DIM - SUB_DIM; k < VEC_DIM; k++)
            queue_item(pqdt_pkg::FUNC_QUERY, k, 16'h8000);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            write_mode(phase % 2 == 0);
            if (phase == PHASES - 1 || phase == 3)
                idle_odds = 0;
            else
                idle_odds = $urandom_range(2, 6);
            build_phase(PHASE_ITEMS);
        end
        wait_drained();

        if (mismatches == 0 && table_rows.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
